// ===== sv/mrc_pkg.sv =====
// Package for the MAC remap classifier: sizes, status codes and the
// structs passed between the top level and its entry and rule cells.
// No dependencies.
`default_nettype none
package mrc_pkg;

  localparam int REMAP_ENTRIES    = 128;
  localparam int FILTER_SLOTS     = 8;
  localparam int RULES_PER_FILTER = 16;
  localparam int RULE_TOTAL       = FILTER_SLOTS * RULES_PER_FILTER;

  localparam int ENTRY_W = $clog2(REMAP_ENTRIES);
  localparam int RULE_W  = $clog2(RULE_TOTAL);

  localparam logic [1:0] ACT_CLASSIFY = 2'd0;
  localparam logic [1:0] ACT_WRITE    = 2'd1;
  localparam logic [1:0] ACT_DELETE   = 2'd2;
  localparam logic [1:0] ACT_RULE     = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NO_REMAP  = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [1:0] CLS_ANY   = 2'd0;
  localparam logic [1:0] CLS_TCP   = 2'd1;
  localparam logic [1:0] CLS_UDP   = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  localparam logic [1:0] IP_ANY    = 2'd0;
  localparam logic [1:0] IP_EXACT  = 2'd1;
  localparam logic [1:0] IP_SUBNET = 2'd2;
  localparam logic [1:0] IP_RANGE  = 2'd3;

  localparam logic [1:0] PORT_EXACT = 2'd1;
  localparam logic [1:0] PORT_RANGE = 2'd2;

  localparam logic [1:0] WSEL_CTRL = 2'd0;
  localparam logic [1:0] WSEL_ADDR = 2'd1;
  localparam logic [1:0] WSEL_PORT = 2'd2;
  localparam logic [1:0] WSEL_BAD  = 2'd3;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  // Entry update broadcast to all entry cells; each cell has its own enable.
  typedef struct packed {
    logic        set;
    logic        clr;
    logic [47:0] match_mac;
    logic [47:0] replace_mac;
    logic [4:0]  egress;
    logic [2:0]  filter;
  } entry_wr_t;

  // Entry contents, zero unless the cell hit.
  typedef struct packed {
    logic [47:0] replace_mac;
    logic [4:0]  egress;
    logic [2:0]  filter;
  } entry_data_t;

  // Frame header fields that every rule cell checks.
  typedef struct packed {
    logic [1:0]  cls;
    logic        ports;
    logic [31:0] src_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] frame_length;
  } frame_t;

endpackage
`default_nettype wire

// ===== sv/mac_remap_ipv4_classifier_core.sv =====
// MAC remap classifier, top level: a chain of entry cells and a row of rule
// cells with a small sequencer. Depends on mrc_pkg, mrc_entry_cell, mrc_rule_cell.
// The sequencer takes one item at a time and accepts no new beat until the
// result is loaded into the output register; its steps are key compare, entry
// select and table write, rule compare, result.
// Reset: asynchronous, active low; clears all entry valid bits and rule controls.
`default_nettype none
module mac_remap_ipv4_classifier_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [47:0] dest_mac_i,
  input  wire logic [15:0] ether_type_i,
  input  wire logic [7:0]  ip_protocol_i,
  input  wire logic [31:0] src_ip_i,
  input  wire logic [15:0] sport_i,
  input  wire logic [15:0] dport_i,
  input  wire logic [15:0] frame_length_i,
  input  wire logic [2:0]  filter_slot_i,
  input  wire logic [3:0]  rule_slot_i,
  input  wire logic [1:0]  word_select_i,
  input  wire logic [63:0] write_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [47:0]      out_mac_o,
  output logic             egress_valid_o,
  output logic [3:0]       egress_port_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_SEL  = 3'd2;
  localparam logic [2:0] S_RULE = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam int NE = mrc_pkg::REMAP_ENTRIES;
  localparam int NR = mrc_pkg::RULE_TOTAL;

  logic [2:0] state_q, state_d;

  logic [1:0]  act_q;
  logic [47:0] mac_q;
  logic [15:0] eth_q;
  logic [2:0]  fslot_q;
  logic [3:0]  rslot_q;
  logic [1:0]  wsel_q;
  logic [63:0] data_q;
  mrc_pkg::frame_t frame_q, frame_d;

  logic        found_q;
  mrc_pkg::entry_data_t sel_q, sel_d;

  logic        out_valid_q;
  logic [1:0]  status_q, status_d;
  logic [47:0] omac_q, omac_d;
  logic        ev_q, ev_d;
  logic [3:0]  ep_q, ep_d;

  logic [NE:0]   free_chain;
  logic [NE-1:0] hit_vec, take_vec, entry_we;
  mrc_pkg::entry_data_t entry_data [NE];
  mrc_pkg::entry_wr_t   ewr;
  logic [NR-1:0] pass_vec;
  logic [2:0]    rule_we [NR];

  logic found_now, any_free, any_pass, filter_ok, rule_ok, out_load;
  logic [mrc_pkg::RULE_W-1:0] widx, ridx;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = !out_valid_q || out_ready_i;

  always_comb begin
    frame_d.cls = (ip_protocol_i == mrc_pkg::PROTO_TCP) ? mrc_pkg::CLS_TCP :
                  (ip_protocol_i == mrc_pkg::PROTO_UDP) ? mrc_pkg::CLS_UDP :
                  mrc_pkg::CLS_OTHER;
    frame_d.ports        = (frame_d.cls != mrc_pkg::CLS_OTHER);
    frame_d.src_ip       = src_ip_i;
    frame_d.sport        = sport_i;
    frame_d.dport        = dport_i;
    frame_d.frame_length = frame_length_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q   <= action_i;
      mac_q   <= dest_mac_i;
      eth_q   <= ether_type_i;
      fslot_q <= filter_slot_i;
      rslot_q <= rule_slot_i;
      wsel_q  <= word_select_i;
      data_q  <= write_data_i;
      frame_q <= frame_d;
    end
  end

  // Entry cells; the free token ripples from cell zero upward.
  assign free_chain[0] = 1'b0;
  for (genvar k = 0; k < NE; k++) begin : g_entry
    mrc_entry_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .key_i       (mac_q),
      .free_seen_i (free_chain[k]),
      .free_seen_o (free_chain[k+1]),
      .take_o      (take_vec[k]),
      .we_i        (entry_we[k]),
      .wr_i        (ewr),
      .hit_o       (hit_vec[k]),
      .data_o      (entry_data[k])
    );
  end

  assign found_now = |hit_vec;
  assign any_free  = free_chain[NE];

  always_comb begin
    sel_d = '0;
    for (int k = 0; k < NE; k++) sel_d = sel_d | entry_data[k];
  end

  always_comb begin
    ewr.set         = (act_q == mrc_pkg::ACT_WRITE) &&
                      (32'(fslot_q) < 32'(mrc_pkg::FILTER_SLOTS));
    ewr.clr         = (act_q == mrc_pkg::ACT_DELETE);
    ewr.match_mac   = mac_q;
    ewr.replace_mac = data_q[47:0];
    ewr.egress      = data_q[52:48];
    ewr.filter      = fslot_q;
    for (int k = 0; k < NE; k++) begin
      entry_we[k] = (state_q == S_SEL) && (ewr.set || ewr.clr) &&
                    (hit_vec[k] || (ewr.set && !found_now && take_vec[k]));
    end
  end

  // Rule cells.
  assign rule_ok = (32'(fslot_q) < 32'(mrc_pkg::FILTER_SLOTS)) &&
                   (32'(rslot_q) < 32'(mrc_pkg::RULES_PER_FILTER)) &&
                   (wsel_q != mrc_pkg::WSEL_BAD);
  assign widx = mrc_pkg::RULE_W'(int'(fslot_q) * mrc_pkg::RULES_PER_FILTER + int'(rslot_q));

  for (genvar r = 0; r < NR; r++) begin : g_rule
    always_comb begin
      rule_we[r] = 3'b000;
      if (state_q == S_SEL && act_q == mrc_pkg::ACT_RULE && rule_ok &&
          widx == mrc_pkg::RULE_W'(r)) begin
        rule_we[r][0] = (wsel_q == mrc_pkg::WSEL_CTRL);
        rule_we[r][1] = (wsel_q == mrc_pkg::WSEL_ADDR);
        rule_we[r][2] = (wsel_q == mrc_pkg::WSEL_PORT);
      end
    end
    mrc_rule_cell u_rule (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .we_i    (rule_we[r]),
      .data_i  (data_q),
      .frame_i (frame_q),
      .pass_o  (pass_vec[r])
    );
  end

  assign filter_ok = 32'(sel_q.filter) < 32'(mrc_pkg::FILTER_SLOTS);

  always_comb begin
    any_pass = 1'b0;
    ridx     = '0;
    for (int r = 0; r < mrc_pkg::RULES_PER_FILTER; r++) begin
      ridx     = mrc_pkg::RULE_W'(int'(sel_q.filter) * mrc_pkg::RULES_PER_FILTER + r);
      any_pass = any_pass | pass_vec[ridx];
    end
  end

  // Result of the current item, loaded into the output register.
  always_comb begin
    status_d = mrc_pkg::ST_DONE;
    omac_d   = mac_q;
    ev_d     = 1'b0;
    ep_d     = 4'd0;
    case (act_q)
      mrc_pkg::ACT_CLASSIFY: begin
        status_d = mrc_pkg::ST_NO_REMAP;
        if (found_q && eth_q == mrc_pkg::ETH_IPV4 && filter_ok && any_pass) begin
          status_d = mrc_pkg::ST_DONE;
          omac_d   = sel_q.replace_mac;
          ev_d     = sel_q.egress[4];
          ep_d     = sel_q.egress[4] ? sel_q.egress[3:0] : 4'd0;
        end
      end
      mrc_pkg::ACT_WRITE: begin
        if (32'(fslot_q) >= 32'(mrc_pkg::FILTER_SLOTS)) status_d = mrc_pkg::ST_NOT_FOUND;
        else if (!found_q && !any_free)                status_d = mrc_pkg::ST_FULL;
      end
      mrc_pkg::ACT_DELETE: begin
        if (!found_q) status_d = mrc_pkg::ST_NOT_FOUND;
      end
      default: begin
        if (!rule_ok) status_d = mrc_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // The free flag is sampled with the entry select, before the table write.
  logic any_free_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_LOOK;
      S_LOOK: state_d = S_SEL;
      S_SEL:  state_d = S_RULE;
      S_RULE: state_d = S_FIN;
      S_FIN:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIN && out_load) out_valid_q <= 1'b1;
      else if (out_ready_i)             out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SEL) begin
      found_q    <= found_now;
      sel_q      <= sel_d;
      any_free_q <= any_free;
    end
    if (state_q == S_FIN && out_load) begin
      status_q <= (act_q == mrc_pkg::ACT_WRITE && status_d == mrc_pkg::ST_FULL && any_free_q)
                  ? mrc_pkg::ST_DONE : status_d;
      omac_q   <= omac_d;
      ev_q     <= ev_d;
      ep_q     <= ep_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_mac_o      = omac_q;
  assign egress_valid_o = ev_q;
  assign egress_port_o  = ep_q;

  // MAC keys are unique in the table, so at most one cell can hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(hit_vec))
    else $error("more than one remap entry hit");
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(take_vec))
    else $error("more than one free entry selected");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_FIN && !out_load) |=> (state_q == S_FIN))
    else $error("result dropped while output register is full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q != S_SEL) |-> (entry_we == '0))
    else $error("entry written outside the select step");

endmodule
`default_nettype wire

// ===== sv/mrc_entry_cell.sv =====
// One remap entry cell: holds an entry, compares it with the key and
// passes the free-slot token to its neighbor. Depends on mrc_pkg.
`default_nettype none
module mrc_entry_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [47:0]        key_i,
  input  wire logic               free_seen_i,
  output logic                    free_seen_o,
  output logic                    take_o,
  input  wire logic               we_i,
  input  wire mrc_pkg::entry_wr_t wr_i,
  output logic                    hit_o,
  output mrc_pkg::entry_data_t    data_o
);

  logic        valid_q;
  logic        hit_q;
  logic [47:0] match_q;
  mrc_pkg::entry_data_t data_q;

  assign free_seen_o = free_seen_i | ~valid_q;
  assign take_o      = ~valid_q & ~free_seen_i;
  assign hit_o       = hit_q;
  assign data_o      = hit_q ? data_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      hit_q <= valid_q && (match_q == key_i);
      if (we_i && wr_i.set) valid_q <= 1'b1;
      else if (we_i && wr_i.clr) valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && wr_i.set) begin
      match_q            <= wr_i.match_mac;
      data_q.replace_mac <= wr_i.replace_mac;
      data_q.egress      <= wr_i.egress;
      data_q.filter      <= wr_i.filter;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mrc_rule_cell.sv =====
// One rule cell: holds the control, address and port words of a rule and
// registers whether the current frame passes it. Depends on mrc_pkg.
`default_nettype none
module mrc_rule_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [2:0]      we_i,
  input  wire logic [63:0]     data_i,
  input  wire mrc_pkg::frame_t frame_i,
  output logic                 pass_o
);

  logic [25:0] ctrl_q;
  logic [63:0] addr_q;
  logic [63:0] port_q;
  logic        pass_q;
  logic        pass_d;

  logic [1:0]  rcls;
  logic [15:0] minlen;
  logic [1:0]  ipk, spk, dpk;
  logic [31:0] lo32, hi32;
  logic        ip_ok, sp_ok, dp_ok;

  always_comb begin
    rcls   = ctrl_q[2:1];
    minlen = ctrl_q[19:4];
    ipk    = ctrl_q[21:20];
    spk    = ctrl_q[23:22];
    dpk    = ctrl_q[25:24];
    lo32   = addr_q[31:0];
    hi32   = addr_q[63:32];
    case (ipk)
      mrc_pkg::IP_EXACT:  ip_ok = frame_i.src_ip == lo32;
      mrc_pkg::IP_SUBNET: ip_ok = (frame_i.src_ip & hi32) == lo32;
      mrc_pkg::IP_RANGE:  ip_ok = (frame_i.src_ip >= lo32) && (frame_i.src_ip <= hi32);
      default:            ip_ok = 1'b1;
    endcase
    case (spk)
      mrc_pkg::PORT_EXACT: sp_ok = frame_i.sport == port_q[15:0];
      mrc_pkg::PORT_RANGE: sp_ok = (frame_i.sport >= port_q[15:0]) &&
                                   (frame_i.sport <= port_q[31:16]);
      default:             sp_ok = 1'b1;
    endcase
    case (dpk)
      mrc_pkg::PORT_EXACT: dp_ok = frame_i.dport == port_q[47:32];
      mrc_pkg::PORT_RANGE: dp_ok = (frame_i.dport >= port_q[47:32]) &&
                                   (frame_i.dport <= port_q[63:48]);
      default:             dp_ok = 1'b1;
    endcase
    pass_d = ctrl_q[0] && !ctrl_q[3] &&
             ((rcls == mrc_pkg::CLS_ANY) || (rcls == frame_i.cls)) &&
             (frame_i.frame_length >= minlen) && ip_ok &&
             (!frame_i.ports || (sp_ok && dp_ok));
  end

  assign pass_o = pass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      pass_q <= 1'b0;
    end else begin
      pass_q <= pass_d;
      if (we_i[0]) ctrl_q <= data_i[25:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i[1]) addr_q <= data_i;
    if (we_i[2]) port_q <= data_i;
  end

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Testbench for mac_remap_ipv4_classifier_core: directed and random beats,
// scored against a behavioral model of the remap and rule tables.
// Depends on mrc_pkg and the RTL of the classifier.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] mac;
    logic        ev;
    logic [3:0]  port;
  } remap_result_t;

  typedef struct {
    logic [1:0]  action;
    logic [47:0] dest_mac;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] src_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] frame_length;
    logic [2:0]  filter_slot;
    logic [3:0]  rule_slot;
    logic [1:0]  word_select;
    logic [63:0] write_data;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0]  action_i = '0;
  logic [47:0] dest_mac_i = '0;
  logic [15:0] ether_type_i = '0;
  logic [7:0]  ip_protocol_i = '0;
  logic [31:0] src_ip_i = '0;
  logic [15:0] sport_i = '0;
  logic [15:0] dport_i = '0;
  logic [15:0] frame_length_i = '0;
  logic [2:0]  filter_slot_i = '0;
  logic [3:0]  rule_slot_i = '0;
  logic [1:0]  word_select_i = '0;
  logic [63:0] write_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [47:0] out_mac_o;
  logic        egress_valid_o;
  logic [3:0]  egress_port_o;

  always #5 clk_i = ~clk_i;

  mac_remap_ipv4_classifier_core dut (.*);

  // Model state.
  logic        ent_valid [mrc_pkg::REMAP_ENTRIES];
  logic [47:0] ent_match [mrc_pkg::REMAP_ENTRIES];
  logic [47:0] ent_repl  [mrc_pkg::REMAP_ENTRIES];
  logic [4:0]  ent_egress[mrc_pkg::REMAP_ENTRIES];
  logic [2:0]  ent_filter[mrc_pkg::REMAP_ENTRIES];
  logic [25:0] rule_ctrl [mrc_pkg::RULE_TOTAL];
  logic [63:0] rule_addr [mrc_pkg::RULE_TOTAL];
  logic [63:0] rule_port [mrc_pkg::RULE_TOTAL];
  // Tracks which rule words were written so random rules never read unwritten ones.
  logic        addr_set  [mrc_pkg::RULE_TOTAL];
  logic        port_set  [mrc_pkg::RULE_TOTAL];

  remap_result_t expected_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  int quiet_cycles = 0;
  logic [47:0] mac_pool[16];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic int lookup_entry(logic [47:0] mac);
    for (int k = 0; k < mrc_pkg::REMAP_ENTRIES; k++)
      if (ent_valid[k] && ent_match[k] == mac) return k;
    return -1;
  endfunction

  function automatic bit port_match(logic [1:0] kind, logic [15:0] p,
                                    logic [15:0] lo, logic [15:0] hi);
    if (kind == mrc_pkg::PORT_EXACT) return p == lo;
    if (kind == mrc_pkg::PORT_RANGE) return p >= lo && p <= hi;
    return 1'b1;
  endfunction

  function automatic bit rule_hit(int idx, logic [1:0] cls, beat_t b);
    logic [25:0] c;
    logic [31:0] lo, hi;
    c = rule_ctrl[idx];
    lo = rule_addr[idx][31:0];
    hi = rule_addr[idx][63:32];
    if (!c[0] || c[3]) return 1'b0;
    if (c[2:1] != mrc_pkg::CLS_ANY && c[2:1] != cls) return 1'b0;
    if (b.frame_length < c[19:4]) return 1'b0;
    if (c[21:20] == mrc_pkg::IP_EXACT && b.src_ip != lo) return 1'b0;
    if (c[21:20] == mrc_pkg::IP_SUBNET && (b.src_ip & hi) != lo) return 1'b0;
    if (c[21:20] == mrc_pkg::IP_RANGE && (b.src_ip < lo || b.src_ip > hi)) return 1'b0;
    if (cls == mrc_pkg::CLS_OTHER) return 1'b1;
    if (!port_match(c[23:22], b.sport, rule_port[idx][15:0], rule_port[idx][31:16]))
      return 1'b0;
    return port_match(c[25:24], b.dport, rule_port[idx][47:32], rule_port[idx][63:48]);
  endfunction

  function automatic remap_result_t predict_remap(beat_t b);
    remap_result_t r;
    int k;
    int base;
    logic [1:0] cls;
    r = '{status: mrc_pkg::ST_DONE, mac: b.dest_mac, ev: 1'b0, port: 4'd0};
    case (b.action)
      mrc_pkg::ACT_CLASSIFY: begin
        r.status = mrc_pkg::ST_NO_REMAP;
        k = lookup_entry(b.dest_mac);
        if (k >= 0 && b.ether_type == mrc_pkg::ETH_IPV4) begin
          cls = b.ip_protocol == mrc_pkg::PROTO_TCP ? mrc_pkg::CLS_TCP :
                (b.ip_protocol == mrc_pkg::PROTO_UDP ? mrc_pkg::CLS_UDP :
                 mrc_pkg::CLS_OTHER);
          base = int'(ent_filter[k]) * mrc_pkg::RULES_PER_FILTER;
          for (int i = 0; i < mrc_pkg::RULES_PER_FILTER; i++) begin
            if (rule_hit(base + i, cls, b)) begin
              r.status = mrc_pkg::ST_DONE;
              r.mac = ent_repl[k];
              r.ev = ent_egress[k][4];
              r.port = r.ev ? ent_egress[k][3:0] : 4'd0;
              break;
            end
          end
        end
      end
      mrc_pkg::ACT_WRITE: begin
        k = lookup_entry(b.dest_mac);
        if (k < 0)
          for (int i = mrc_pkg::REMAP_ENTRIES - 1; i >= 0; i--)
            if (!ent_valid[i]) k = i;
        if (k < 0) begin
          r.status = mrc_pkg::ST_FULL;
        end else begin
          ent_valid[k] = 1'b1;
          ent_match[k] = b.dest_mac;
          ent_repl[k] = b.write_data[47:0];
          ent_egress[k] = b.write_data[52:48];
          ent_filter[k] = b.filter_slot;
        end
      end
      mrc_pkg::ACT_DELETE: begin
        k = lookup_entry(b.dest_mac);
        if (k < 0) r.status = mrc_pkg::ST_NOT_FOUND;
        else ent_valid[k] = 1'b0;
      end
      default: begin
        if (b.word_select > mrc_pkg::WSEL_PORT) begin
          r.status = mrc_pkg::ST_NOT_FOUND;
        end else begin
          k = int'(b.filter_slot) * mrc_pkg::RULES_PER_FILTER + int'(b.rule_slot);
          if (b.word_select == mrc_pkg::WSEL_CTRL) rule_ctrl[k] = b.write_data[25:0];
          else if (b.word_select == mrc_pkg::WSEL_ADDR) begin
            rule_addr[k] = b.write_data;
            addr_set[k] = 1'b1;
          end else begin
            rule_port[k] = b.write_data;
            port_set[k] = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Valid stays high into the next beat when the sender does not idle.
  task automatic send_beat(input beat_t b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    action_i <= b.action;
    dest_mac_i <= b.dest_mac;
    ether_type_i <= b.ether_type;
    ip_protocol_i <= b.ip_protocol;
    src_ip_i <= b.src_ip;
    sport_i <= b.sport;
    dport_i <= b.dport;
    frame_length_i <= b.frame_length;
    filter_slot_i <= b.filter_slot;
    rule_slot_i <= b.rule_slot;
    word_select_i <= b.word_select;
    write_data_i <= b.write_data;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(predict_remap(b));
  endtask

  function automatic beat_t random_beat();
    beat_t b;
    b.action = 2'($urandom_range(3));
    b.dest_mac = 48'({$urandom, $urandom});
    b.ether_type = 16'($urandom);
    b.ip_protocol = 8'($urandom);
    b.src_ip = $urandom;
    b.sport = 16'($urandom);
    b.dport = 16'($urandom);
    b.frame_length = 16'($urandom);
    b.filter_slot = 3'($urandom);
    b.rule_slot = 4'($urandom);
    b.word_select = 2'($urandom);
    b.write_data = {$urandom, $urandom};
    return b;
  endfunction

  // Writes all three words of one rule; the control word goes last.
  task automatic write_rule(input int f, input int s, input logic [25:0] ctrl,
                            input logic [63:0] addr, input logic [63:0] ports);
    beat_t b;
    b = random_beat();
    b.action = mrc_pkg::ACT_RULE;
    b.filter_slot = 3'(f);
    b.rule_slot = 4'(s);
    b.word_select = mrc_pkg::WSEL_ADDR;
    b.write_data = addr;
    send_beat(b);
    b.word_select = mrc_pkg::WSEL_PORT;
    b.write_data = ports;
    send_beat(b);
    b.word_select = mrc_pkg::WSEL_CTRL;
    b.write_data = {38'($urandom), ctrl};
    send_beat(b);
  endtask

  task automatic write_entry(input logic [47:0] key, input int f,
                             input logic [63:0] data);
    beat_t b;
    b = random_beat();
    b.action = mrc_pkg::ACT_WRITE;
    b.dest_mac = key;
    b.filter_slot = 3'(f);
    b.write_data = data;
    send_beat(b);
  endtask

  task automatic send_frame(input logic [47:0] key, input logic [7:0] proto,
                            input logic [31:0] sip, input logic [15:0] len);
    beat_t b;
    b = random_beat();
    b.action = mrc_pkg::ACT_CLASSIFY;
    b.dest_mac = key;
    b.ether_type = mrc_pkg::ETH_IPV4;
    b.ip_protocol = proto;
    b.src_ip = sip;
    b.frame_length = len;
    send_beat(b);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", 64'(status_o), 64'd0);
      end else begin
        remap_result_t e;
        e = expected_q.pop_front();
        if (status_o != e.status) report_mismatch("status", 64'(status_o), 64'(e.status));
        if (out_mac_o != e.mac) report_mismatch("out_mac", 64'(out_mac_o), 64'(e.mac));
        if (egress_valid_o != e.ev)
          report_mismatch("egress_valid", 64'(egress_valid_o), 64'(e.ev));
        if (egress_port_o != e.port)
          report_mismatch("egress_port", 64'(egress_port_o), 64'(e.port));
      end
    end
    out_ready_i <= !recv_hold && !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_edges();
    beat_t b;
    // Classify on an empty table, every ethertype flavor.
    send_frame('0, mrc_pkg::PROTO_TCP, '0, '0);
    b = random_beat();
    b.action = mrc_pkg::ACT_CLASSIFY;
    b.ether_type = mrc_pkg::ETH_IPV6;
    send_beat(b);
    // Delete of an unknown key, bad word select.
    b.action = mrc_pkg::ACT_DELETE;
    b.dest_mac = '1;
    send_beat(b);
    b.action = mrc_pkg::ACT_RULE;
    b.word_select = mrc_pkg::WSEL_BAD;
    send_beat(b);
    // Any-rule in filter 7, entry with egress, then remap of all ones.
    write_rule(7, 15, 26'h1, '1, '1);
    write_entry('1, 7, 64'h001F_FFFF_FFFF_FFFF);
    send_frame('1, 8'hFF, '1, '1);
    b = random_beat();
    b.action = mrc_pkg::ACT_CLASSIFY;
    b.dest_mac = '1;
    b.ether_type = mrc_pkg::ETH_IPV6;
    send_beat(b);
    // Update in place without egress, then delete.
    write_entry('1, 7, 64'h0000_1234_5678_9ABC);
    send_frame('1, mrc_pkg::PROTO_UDP, '0, '0);
    b.action = mrc_pkg::ACT_DELETE;
    send_beat(b);
    send_frame('1, mrc_pkg::PROTO_UDP, '0, '0);
    b.action = mrc_pkg::ACT_DELETE;
    send_beat(b);
    wait_drained();
  endtask

  task automatic test_table_full();
    for (int i = 0; i <= mrc_pkg::REMAP_ENTRIES; i++)
      write_entry(48'h0A00_0000_0000 + 48'(i), i % mrc_pkg::FILTER_SLOTS,
                  {$urandom, $urandom});
    send_frame(48'h0A00_0000_0005, mrc_pkg::PROTO_TCP, $urandom, '1);
    for (int i = 0; i < mrc_pkg::REMAP_ENTRIES; i++) begin
      beat_t b;
      b = random_beat();
      b.action = mrc_pkg::ACT_DELETE;
      b.dest_mac = 48'h0A00_0000_0000 + 48'(i);
      send_beat(b);
    end
    wait_drained();
  endtask

  // Random rules over all match kinds with frames that often hit them.
  task automatic test_random(input int count);
    int n;
    logic [25:0] c;
    logic [31:0] a, m;
    int f, s;
    beat_t b;
    n = 0;
    while (n < count) begin
      case ($urandom_range(9))
        0, 1: begin
          f = $urandom_range(7);
          s = $urandom_range(15);
          a = $urandom;
          m = $urandom;
          c = 26'($urandom);
          c[0] = ($urandom_range(4) != 0);
          c[3] = ($urandom_range(7) == 0);
          c[19:4] = 16'($urandom_range(1)) ? 16'($urandom_range(200)) : 16'($urandom);
          if (c[21:20] == mrc_pkg::IP_SUBNET) a = a & m;
          if (c[21:20] == mrc_pkg::IP_RANGE && a > m) {a, m} = {m, a};
          write_rule(f, s, c, {m, a}, {$urandom, $urandom});
          n += 3;
        end
        2: begin
          write_entry(mac_pool[$urandom_range(15)], $urandom_range(7), {$urandom, $urandom});
          n++;
        end
        3: begin
          b = random_beat();
          b.action = mrc_pkg::ACT_DELETE;
          if ($urandom_range(1)) b.dest_mac = mac_pool[$urandom_range(15)];
          send_beat(b);
          n++;
        end
        9: begin
          b = random_beat();
          if (b.action == mrc_pkg::ACT_RULE && b.word_select != mrc_pkg::WSEL_BAD) begin
            f = int'(b.filter_slot) * mrc_pkg::RULES_PER_FILTER + int'(b.rule_slot);
            if (!addr_set[f] || !port_set[f]) b.word_select = mrc_pkg::WSEL_BAD;
          end
          send_beat(b);
          n++;
        end
        default: begin
          b = random_beat();
          b.action = mrc_pkg::ACT_CLASSIFY;
          b.dest_mac = mac_pool[$urandom_range(15)];
          if ($urandom_range(7) != 0) b.ether_type = mrc_pkg::ETH_IPV4;
          case ($urandom_range(3))
            0: b.ip_protocol = mrc_pkg::PROTO_TCP;
            1: b.ip_protocol = mrc_pkg::PROTO_UDP;
            2: b.sport = 16'($urandom_range(3));
            default: ;
          endcase
          if ($urandom_range(1)) b.frame_length = 16'($urandom_range(300));
          send_beat(b);
          n++;
        end
      endcase
    end
  endtask

  task automatic test_backpressure();
    recv_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      test_random(20);
    join
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < mrc_pkg::REMAP_ENTRIES; i++) ent_valid[i] = 1'b0;
    for (int i = 0; i < mrc_pkg::RULE_TOTAL; i++) begin
      rule_ctrl[i] = '0;
      rule_addr[i] = '0;
      rule_port[i] = '0;
      addr_set[i] = 1'b0;
      port_set[i] = 1'b0;
    end
    for (int i = 0; i < 16; i++) mac_pool[i] = 48'({$urandom, $urandom});
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edges();
    test_table_full();
    send_idle_pct = 19;
    recv_idle_pct = 58;
    test_random(100);
    test_backpressure();
    send_idle_pct = 58;
    recv_idle_pct = 19;
    test_random(100);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(100);
    wait_drained();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
